// File: sv/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, codes and controller/datapath interface types for the
// first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned MEM_BYTES   = 65536;
  localparam int unsigned STORE_WORDS = MEM_BYTES / 4;
  localparam int unsigned IDX_W       = $clog2(STORE_WORDS);
  localparam int unsigned WALK_MAX    = MEM_BYTES / 8;
  localparam int unsigned WALK_W      = $clog2(WALK_MAX) + 1;

  localparam logic [31:0] USED_MARK     = 32'hFFFF_FFFF;
  localparam logic [15:0] FREE_FLOOR    = 16'd4096;
  localparam logic [16:0] HEAP_TOP_RST  = 17'd4096;
  localparam logic [16:0] MEM_LIMIT_RST = 17'd65536;
  localparam logic [17:0] HDR_BYTES     = 18'd8;

  // configuration register indexes
  localparam logic CFG_MEM_LIMIT  = 1'b0;
  localparam logic CFG_HEAP_START = 1'b1;

  typedef enum logic [2:0] {
    ST_REUSED  = 3'd0,
    ST_NEW     = 3'd1,
    ST_ZERO    = 3'd2,
    ST_OOM     = 3'd3,
    ST_FREED   = 3'd4,
    ST_DOUBLE  = 3'd5,
    ST_INVALID = 3'd6,
    ST_NULL    = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WALK_CHK,
    S_WALK_SIZE,
    S_WALK_NEXT,
    S_TAKE,
    S_BUMP,
    S_BUMP_W2,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    A_CUR,
    A_CUR4,
    A_PREV4,
    A_TOP
  } addr_sel_e;

  typedef enum logic [1:0] {
    W_SIZE,
    W_USED,
    W_NEXT,
    W_HEAD
  } wdata_sel_e;

  typedef struct packed {
    logic       clr;
    logic       start;
    addr_sel_e  asel;
    logic       rd;
    logic       wr;
    wdata_sel_e wsel;
    logic       walk_init;
    logic       walk_adv;
    logic       fit_load;
    logic       head_from_next;
    logic       head_from_cur;
    logic       cur_from_blk;
    logic       top_bump;
    logic       st_set;
    status_e    st;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic req_zero;
    logic ptr_null;
    logic blk_ok;
    logic walk_end;
    logic fit;
    logic prev_zero;
    logic oom;
    logic used;
  } dp_stat_t;

endpackage

// File: sv/ffa_dp.sv
// ----------------------------------------------------------------------------
// ffa_dp
// Allocator datapath: header store, list walk registers, heap top, free head,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module ffa_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ffa_pkg::dp_cmd_t cmd_i,
  output ffa_pkg::dp_stat_t stat_o,
  input  logic             action_i,
  input  logic [15:0]      req_size_i,
  input  logic [15:0]      ptr_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_index_i,
  input  logic [16:0]      cfg_data_i,
  output logic [15:0]      result_ptr_o,
  output logic [2:0]       status_o
);

  logic [31:0] hdr_mem_q [ffa_pkg::STORE_WORDS];

  logic [ffa_pkg::IDX_W:0]    clr_cnt_q;
  logic [16:0]                mem_limit_q;
  logic [16:0]                heap_top_q;
  logic [16:0]                free_head_q;
  logic                       action_q;
  logic                       req_zero_q;
  logic [16:0]                size_q;
  logic [15:0]                ptr_q;
  logic [31:0]                cur_q;
  logic [31:0]                prev_q;
  logic [ffa_pkg::WALK_W-1:0] walk_cnt_q;
  logic                       fit_q;
  ffa_pkg::status_e           st_q;
  logic [31:0]                rd_raw_q;
  logic                       rd_win_q;
  logic [15:0]                result_ptr_q;
  logic [2:0]                 status_q;

  logic [31:0]                win;
  logic [31:0]                addr;
  logic                       in_win;
  logic [ffa_pkg::IDX_W-1:0]  idx;
  logic [31:0]                wdata;
  logic [31:0]                rdata;
  logic [15:0]                blk16;
  logic [17:0]                top_next;

  // usable window is the smaller of the register and the store size
  assign win = ({15'd0, mem_limit_q} > 32'(ffa_pkg::MEM_BYTES)) ?
               32'(ffa_pkg::MEM_BYTES) : {15'd0, mem_limit_q};

  always_comb begin
    case (cmd_i.asel)
      ffa_pkg::A_CUR:   addr = cur_q;
      ffa_pkg::A_CUR4:  addr = cur_q + 32'd4;
      ffa_pkg::A_PREV4: addr = prev_q + 32'd4;
      ffa_pkg::A_TOP:   addr = {15'd0, heap_top_q};
      default:          addr = cur_q;
    endcase
  end

  assign in_win = (addr != 32'd0) && (addr < win);
  assign idx    = addr[ffa_pkg::IDX_W+1:2];
  assign rdata  = rd_win_q ? rd_raw_q : 32'd0;

  always_comb begin
    case (cmd_i.wsel)
      ffa_pkg::W_SIZE: wdata = {15'd0, size_q};
      ffa_pkg::W_USED: wdata = ffa_pkg::USED_MARK;
      ffa_pkg::W_NEXT: wdata = rdata;
      ffa_pkg::W_HEAD: wdata = {15'd0, free_head_q};
      default:         wdata = 32'd0;
    endcase
  end

  assign blk16    = ptr_q - 16'd8;
  assign top_next = {1'b0, heap_top_q} + ffa_pkg::HDR_BYTES + {1'b0, size_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      hdr_mem_q[clr_cnt_q[ffa_pkg::IDX_W-1:0]] <= 32'd0;
    end else if (cmd_i.wr && in_win) begin
      hdr_mem_q[idx] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_raw_q <= hdr_mem_q[idx];
      rd_win_q <= in_win;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      mem_limit_q <= ffa_pkg::MEM_LIMIT_RST;
      heap_top_q  <= ffa_pkg::HEAP_TOP_RST;
      free_head_q <= 17'd0;
    end else begin
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ffa_pkg::CFG_MEM_LIMIT:  mem_limit_q <= cfg_data_i;
          ffa_pkg::CFG_HEAP_START: heap_top_q  <= {1'b0, cfg_data_i[15:0]};
          default:                 mem_limit_q <= mem_limit_q;
        endcase
      end else if (cmd_i.top_bump) begin
        heap_top_q <= top_next[16:0];
      end
      if (cmd_i.head_from_next) begin
        free_head_q <= rdata[16:0];
      end else if (cmd_i.head_from_cur) begin
        free_head_q <= cur_q[16:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      action_q   <= action_i;
      req_zero_q <= (req_size_i == 16'd0);
      size_q     <= ({1'b0, req_size_i} + 17'd7) & ~17'd7;
      ptr_q      <= ptr_i;
    end
    if (cmd_i.walk_init) begin
      cur_q      <= {15'd0, free_head_q};
      prev_q     <= 32'd0;
      walk_cnt_q <= '0;
    end else if (cmd_i.walk_adv) begin
      prev_q     <= cur_q;
      cur_q      <= rdata;
      walk_cnt_q <= walk_cnt_q + 1'b1;
    end else if (cmd_i.cur_from_blk) begin
      cur_q <= {16'd0, blk16};
    end else if (cmd_i.top_bump) begin
      // hold the old top as the new block's header offset
      cur_q <= {15'd0, heap_top_q};
    end
    if (cmd_i.fit_load) begin
      fit_q <= (rdata >= {15'd0, size_q});
    end
    if (cmd_i.st_set) begin
      st_q <= cmd_i.st;
    end
    if (cmd_i.out_load) begin
      if (st_q == ffa_pkg::ST_REUSED || st_q == ffa_pkg::ST_NEW) begin
        result_ptr_q <= cur_q[15:0] + 16'd8;
      end else begin
        result_ptr_q <= 16'd0;
      end
      status_q <= st_q;
    end
  end

  always_comb begin
    stat_o.clr_done  = (clr_cnt_q == (ffa_pkg::IDX_W+1)'(ffa_pkg::STORE_WORDS));
    stat_o.is_free   = action_q;
    stat_o.req_zero  = req_zero_q;
    stat_o.ptr_null  = (ptr_q == 16'd0);
    stat_o.blk_ok    = (ptr_q >= 16'd8) && ({1'b0, blk16} < heap_top_q) &&
                       (blk16 >= ffa_pkg::FREE_FLOOR);
    stat_o.walk_end  = (cur_q == 32'd0) ||
                       (walk_cnt_q == ffa_pkg::WALK_W'(ffa_pkg::WALK_MAX));
    stat_o.fit       = fit_q;
    stat_o.prev_zero = (prev_q == 32'd0);
    stat_o.oom       = ({14'd0, top_next} > win);
    stat_o.used      = (rdata == ffa_pkg::USED_MARK);
  end

  assign result_ptr_o = result_ptr_q;
  assign status_o     = status_q;

endmodule

// File: sv/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Allocator sequencer: store clear after reset, list walk, heap bump, free
// check and output handshake.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ffa_pkg::dp_stat_t stat_i,
  output ffa_pkg::dp_cmd_t  cmd_o
);

  ffa_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffa_pkg::S_CLEAR:     if (stat_i.clr_done) state_d = ffa_pkg::S_IDLE;
      ffa_pkg::S_IDLE:      if (in_valid_i) state_d = ffa_pkg::S_DECODE;
      ffa_pkg::S_DECODE: begin
        if (!stat_i.is_free) begin
          state_d = stat_i.req_zero ? ffa_pkg::S_DONE : ffa_pkg::S_WALK_CHK;
        end else if (stat_i.ptr_null || !stat_i.blk_ok) begin
          state_d = ffa_pkg::S_DONE;
        end else begin
          state_d = ffa_pkg::S_FREE_RD;
        end
      end
      ffa_pkg::S_WALK_CHK:
        state_d = stat_i.walk_end ? ffa_pkg::S_BUMP : ffa_pkg::S_WALK_SIZE;
      ffa_pkg::S_WALK_SIZE: state_d = ffa_pkg::S_WALK_NEXT;
      ffa_pkg::S_WALK_NEXT:
        state_d = stat_i.fit ? ffa_pkg::S_TAKE : ffa_pkg::S_WALK_CHK;
      ffa_pkg::S_TAKE:      state_d = ffa_pkg::S_DONE;
      ffa_pkg::S_BUMP:
        state_d = stat_i.oom ? ffa_pkg::S_DONE : ffa_pkg::S_BUMP_W2;
      ffa_pkg::S_BUMP_W2:   state_d = ffa_pkg::S_DONE;
      ffa_pkg::S_FREE_RD:   state_d = ffa_pkg::S_FREE_CHK;
      ffa_pkg::S_FREE_CHK:  state_d = ffa_pkg::S_DONE;
      ffa_pkg::S_DONE:      if (slot_free) state_d = ffa_pkg::S_IDLE;
      default:              state_d = ffa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.asel = ffa_pkg::A_CUR;
    cmd_o.wsel = ffa_pkg::W_USED;
    cmd_o.st   = ffa_pkg::ST_REUSED;
    in_ready_o = 1'b0;
    case (state_q)
      ffa_pkg::S_CLEAR: cmd_o.clr = !stat_i.clr_done;
      ffa_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ffa_pkg::S_DECODE: begin
        if (!stat_i.is_free) begin
          if (stat_i.req_zero) begin
            cmd_o.st_set = 1'b1;
            cmd_o.st     = ffa_pkg::ST_ZERO;
          end else begin
            cmd_o.walk_init = 1'b1;
          end
        end else if (stat_i.ptr_null) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st     = ffa_pkg::ST_NULL;
        end else if (!stat_i.blk_ok) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st     = ffa_pkg::ST_INVALID;
        end else begin
          cmd_o.cur_from_blk = 1'b1;
        end
      end
      ffa_pkg::S_WALK_CHK: begin
        cmd_o.rd   = !stat_i.walk_end;
        cmd_o.asel = ffa_pkg::A_CUR;
      end
      ffa_pkg::S_WALK_SIZE: begin
        cmd_o.fit_load = 1'b1;
        cmd_o.rd       = 1'b1;
        cmd_o.asel     = ffa_pkg::A_CUR4;
      end
      ffa_pkg::S_WALK_NEXT: begin
        if (stat_i.fit) begin
          // unlink: splice the predecessor or move the head
          if (stat_i.prev_zero) begin
            cmd_o.head_from_next = 1'b1;
          end else begin
            cmd_o.wr   = 1'b1;
            cmd_o.asel = ffa_pkg::A_PREV4;
            cmd_o.wsel = ffa_pkg::W_NEXT;
          end
        end else begin
          cmd_o.walk_adv = 1'b1;
        end
      end
      ffa_pkg::S_TAKE: begin
        cmd_o.wr     = 1'b1;
        cmd_o.asel   = ffa_pkg::A_CUR4;
        cmd_o.wsel   = ffa_pkg::W_USED;
        cmd_o.st_set = 1'b1;
        cmd_o.st     = ffa_pkg::ST_REUSED;
      end
      ffa_pkg::S_BUMP: begin
        cmd_o.st_set = 1'b1;
        if (stat_i.oom) begin
          cmd_o.st = ffa_pkg::ST_OOM;
        end else begin
          cmd_o.st       = ffa_pkg::ST_NEW;
          cmd_o.wr       = 1'b1;
          cmd_o.asel     = ffa_pkg::A_TOP;
          cmd_o.wsel     = ffa_pkg::W_SIZE;
          cmd_o.top_bump = 1'b1;
        end
      end
      ffa_pkg::S_BUMP_W2: begin
        cmd_o.wr   = 1'b1;
        cmd_o.asel = ffa_pkg::A_CUR4;
        cmd_o.wsel = ffa_pkg::W_USED;
      end
      ffa_pkg::S_FREE_RD: begin
        cmd_o.rd   = 1'b1;
        cmd_o.asel = ffa_pkg::A_CUR4;
      end
      ffa_pkg::S_FREE_CHK: begin
        cmd_o.st_set = 1'b1;
        if (stat_i.used) begin
          cmd_o.st            = ffa_pkg::ST_FREED;
          cmd_o.wr            = 1'b1;
          cmd_o.asel          = ffa_pkg::A_CUR4;
          cmd_o.wsel          = ffa_pkg::W_HEAD;
          cmd_o.head_from_cur = 1'b1;
        end else begin
          cmd_o.st = ffa_pkg::ST_DOUBLE;
        end
      end
      ffa_pkg::S_DONE: cmd_o.out_load = slot_free;
      default:         cmd_o.out_load = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffa_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// Heap allocator engine: first-fit free-list walk, heap bump and free check
// over a store of 8-byte block headers.
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  in        in_valid_i/in_ready_o, action_i, req_size_i, ptr_i    in
//  out       out_valid_o/out_ready_i, result_ptr_o, status_o      out
//  cfg       cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i      in
//
//  After reset the header store is cleared one word a cycle, all 16384 words,
//  with in_ready_o low; cfg writes are taken throughout.
//  One item at a time. Free: decode, read, check (or reject at decode).
//  Allocate: decode, check/size/next per entry, then take, bump or OOM.
//  The next item is taken while the result waits; a stalled result holds the
//  engine in its last state.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [15:0] req_size_i,
  input  logic [15:0] ptr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_ptr_o,
  output logic [2:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  ffa_pkg::dp_cmd_t  cmd;
  ffa_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (action_i),
    .req_size_i   (req_size_i),
    .ptr_i        (ptr_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .result_ptr_o (result_ptr_o),
    .status_o     (status_o)
  );

endmodule

// File: tb/sv/first_fit_free_list_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_test
// Drives allocate and free requests through the allocator under random
// handshake gaps and stalls. A heap model tracks the header words, heap top
// and free list, and predicts pointer and status for each transfer. The run
// covers several region limits and heap starts, the extremes among them.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_test;

  localparam int unsigned RUN_LIMIT = 4000000;

  typedef struct {
    logic [15:0]      ptr;
    ffa_pkg::status_e st;
  } alloc_reply_t;

  class heap_scoreboard;
    logic [31:0]  hdr_words [ffa_pkg::STORE_WORDS];
    logic [31:0]  heap_top;
    logic [31:0]  free_head;
    logic [31:0]  mem_limit;
    logic [31:0]  heap_start;
    alloc_reply_t pending [$];
    int           errors;
    int           status_seen [8];

    function new();
      foreach (hdr_words[i]) hdr_words[i] = '0;
      mem_limit  = 32'd65536;
      heap_start = 32'd4096;
      heap_top   = heap_start;
      free_head  = '0;
      errors     = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function logic [31:0] region();
      return (mem_limit > ffa_pkg::MEM_BYTES) ? ffa_pkg::MEM_BYTES : mem_limit;
    endfunction

    function logic [31:0] rd(logic [31:0] off);
      if (off == 0 || off >= region()) return '0;
      return hdr_words[off >> 2];
    endfunction

    function void wr(logic [31:0] off, logic [31:0] v);
      if (off == 0 || off >= region()) return;
      hdr_words[off >> 2] = v;
    endfunction

    function void write_reg(logic idx, logic [16:0] data);
      if (idx == ffa_pkg::CFG_MEM_LIMIT) begin
        mem_limit = {15'd0, data};
      end else begin
        heap_start = {16'd0, data[15:0]};
        heap_top   = heap_start;
      end
    endfunction

    // first-fit walk; unlink the block and mark it used
    function logic [31:0] take_fit(logic [31:0] size);
      logic [31:0] prev;
      logic [31:0] cur;
      logic [31:0] nxt;
      int unsigned n;
      prev = '0;
      cur  = free_head;
      n    = 0;
      while (cur != 0 && n < ffa_pkg::WALK_MAX) begin
        if (rd(cur) >= size) begin
          nxt = rd(cur + 4);
          if (prev == 0) free_head = nxt & 32'h1FFFF;
          else wr(prev + 4, nxt);
          wr(cur + 4, ffa_pkg::USED_MARK);
          return cur;
        end
        prev = cur;
        cur  = rd(cur + 4);
        n++;
      end
      return '0;
    endfunction

    function alloc_reply_t note_request(logic act, logic [15:0] req, logic [15:0] p);
      alloc_reply_t r;
      logic [31:0]  size;
      logic [31:0]  blk;
      logic [31:0]  top;
      r.ptr = '0;
      if (act == 1'b0) begin
        if (req == 0) begin
          r.st = ffa_pkg::ST_ZERO;
        end else begin
          size = ({16'd0, req} + 32'd7) & ~32'd7;
          blk  = take_fit(size);
          if (blk != 0) begin
            r.ptr = 16'(blk + 8);
            r.st  = ffa_pkg::ST_REUSED;
          end else begin
            top = heap_top + 8 + size;
            if (top > region()) begin
              r.st = ffa_pkg::ST_OOM;
            end else begin
              wr(heap_top, size);
              wr(heap_top + 4, ffa_pkg::USED_MARK);
              r.ptr    = 16'(heap_top + 8);
              r.st     = ffa_pkg::ST_NEW;
              heap_top = top & 32'h1FFFF;
            end
          end
        end
      end else begin
        if (p == 0) begin
          r.st = ffa_pkg::ST_NULL;
        end else begin
          blk = {16'd0, p} - 32'd8;
          if (blk < heap_top && blk >= ffa_pkg::FREE_FLOOR) begin
            if (rd(blk + 4) == ffa_pkg::USED_MARK) begin
              wr(blk + 4, free_head);
              free_head = blk & 32'h1FFFF;
              r.st = ffa_pkg::ST_FREED;
            end else begin
              r.st = ffa_pkg::ST_DOUBLE;
            end
          end else begin
            r.st = ffa_pkg::ST_INVALID;
          end
        end
      end
      status_seen[r.st]++;
      pending.push_back(r);
      return r;
    endfunction

    function void check_reply(logic [15:0] p, logic [2:0] st);
      alloc_reply_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: result_ptr=%0d status=%0d", p, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (p !== e.ptr) begin
        $error("result_ptr: expected %0d, got %0d", e.ptr, p);
        errors++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        action_i;
  logic [15:0] req_size_i;
  logic [15:0] ptr_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] result_ptr_o;
  logic [2:0]  status_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [16:0] cfg_data_i;

  heap_scoreboard heap_sb = new();
  logic [15:0]    live_ptrs [$];
  logic [15:0]    freed_ptrs [$];
  bit             steady_in;
  bit             steady_out;
  int unsigned    cycle_count = 0;

  first_fit_free_list_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .req_size_i  (req_size_i),
    .ptr_i       (ptr_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_ptr_o(result_ptr_o),
    .status_o    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("run limit reached with %0d results pending", heap_sb.pending.size());
      $display("[first_fit_free_list_allocator] ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // result side: random stalls, sampled on the pre-edge values
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) heap_sb.check_reply(result_ptr_o, status_o);
      if (steady_out) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ready_i <= (stall_left == 0);
      end
    end
  end

  task automatic write_cfg(logic idx, logic [16:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    heap_sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold the request until transfer, then record it
  task automatic send_request(logic act, logic [15:0] req, logic [15:0] p);
    alloc_reply_t r;
    int gap;
    in_valid_i <= 1'b1;
    action_i   <= act;
    req_size_i <= req;
    ptr_i      <= p;
    do @(posedge clk_i); while (!in_ready_o);
    r = heap_sb.note_request(act, req, p);
    if (r.st == ffa_pkg::ST_NEW || r.st == ffa_pkg::ST_REUSED) live_ptrs.push_back(r.ptr);
    if (r.st == ffa_pkg::ST_FREED) freed_ptrs.push_back(p);
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random();
    int unsigned r;
    int          k;
    logic [15:0] p;
    r = $urandom_range(99);
    if (r < 42) begin
      if ($urandom_range(9) < 8) send_request(1'b0, 16'($urandom_range(1, 64)), 16'($urandom));
      else send_request(1'b0, 16'($urandom_range(65, 600)), 16'($urandom));
    end else if (r < 77 && live_ptrs.size() > 0) begin
      k = $urandom_range(live_ptrs.size() - 1);
      p = live_ptrs[k];
      live_ptrs.delete(k);
      send_request(1'b1, 16'($urandom), p);
    end else if (r < 83 && freed_ptrs.size() > 0) begin
      k = $urandom_range(freed_ptrs.size() - 1);
      send_request(1'b1, 16'($urandom), freed_ptrs[k]);
    end else if (r < 87) begin
      send_request(1'b0, 16'd0, 16'($urandom));
    end else if (r < 90) begin
      send_request(1'b1, 16'($urandom), 16'd0);
    end else if (r < 95) begin
      send_request(1'b1, 16'($urandom), 16'($urandom));
    end else begin
      send_request(1'b0, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (heap_sb.pending.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [16:0] limit, logic [16:0] start, int count);
    write_cfg(ffa_pkg::CFG_MEM_LIMIT, limit);
    write_cfg(ffa_pkg::CFG_HEAP_START, start);
    live_ptrs.delete();
    freed_ptrs.delete();
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        steady_in  = ($urandom_range(4) == 0);
        steady_out = ($urandom_range(4) == 0);
      end
      send_random();
    end
    drain();
  endtask

  initial begin
    logic [15:0] first_ptr;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    action_i    <= 1'b0;
    req_size_i  <= '0;
    ptr_i       <= '0;
    out_ready_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= ffa_pkg::CFG_MEM_LIMIT;
    cfg_data_i  <= '0;
    steady_in   = 1'b0;
    steady_out  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cfg writes are taken while the store is cleared
    write_cfg(ffa_pkg::CFG_MEM_LIMIT, 17'd65536);
    write_cfg(ffa_pkg::CFG_HEAP_START, 16'd4096);

    send_request(1'b0, 16'd0, 16'hFFFF);
    send_request(1'b0, 16'd1, 16'd0);
    first_ptr = live_ptrs[0];
    send_request(1'b0, 16'd8, 16'd0);
    send_request(1'b0, 16'd9, 16'd0);
    send_request(1'b0, 16'hFFFF, 16'd0);
    send_request(1'b1, 16'd0, 16'd0);
    send_request(1'b1, 16'hFFFF, 16'd1);
    send_request(1'b1, 16'd0, 16'hFFFF);
    send_request(1'b1, 16'd0, 16'd4000);
    send_request(1'b1, 16'd0, 16'd4104);
    send_request(1'b1, 16'd0, first_ptr);
    send_request(1'b1, 16'd0, first_ptr);
    send_request(1'b1, 16'd0, live_ptrs[2]);
    send_request(1'b1, 16'd0, live_ptrs[1] + 16'd2);
    send_request(1'b1, 16'd0, live_ptrs[1]);
    send_request(1'b0, 16'd17, 16'd0);
    send_request(1'b0, 16'd4, 16'd0);
    send_request(1'b0, 16'd1, 16'd0);
    send_request(1'b0, 16'd1, 16'd0);
    send_request(1'b1, 16'd0, 16'(heap_sb.heap_top + 8));
    send_request(1'b0, 16'd61000, 16'd0);
    drain();

    run_phase(17'd65536, 17'd4096, 420);
    run_phase(17'd8192, 17'd4096, 180);
    run_phase(17'd0, 17'd4096, 50);
    run_phase(17'h1FFFF, 17'd16384, 300);
    run_phase(17'd65536, 17'hFFFF, 50);
    run_phase(17'd65536, 17'd0, 200);

    $display("covered region limits 0..131071 and heap starts 0..65535");
    $display("status counts: reused %0d new %0d zero %0d oom %0d freed %0d double %0d",
             heap_sb.status_seen[ffa_pkg::ST_REUSED], heap_sb.status_seen[ffa_pkg::ST_NEW],
             heap_sb.status_seen[ffa_pkg::ST_ZERO], heap_sb.status_seen[ffa_pkg::ST_OOM],
             heap_sb.status_seen[ffa_pkg::ST_FREED], heap_sb.status_seen[ffa_pkg::ST_DOUBLE]);
    if (heap_sb.errors == 0 && heap_sb.pending.size() == 0) begin
      $display("[first_fit_free_list_allocator] OK");
    end else begin
      $display("[first_fit_free_list_allocator] ERROR");
    end
    $finish;
  end

endmodule
